>>> hdl/pcw_pkg.sv
// shared constants, types and width helpers for the point curvature window
`default_nettype none
package pcw_pkg;

  localparam int COORD_W = 18;
  localparam int IDX_W   = 17;
  localparam int CURV_W  = 45;

  localparam int INDEX_MAX = 131071;

  localparam logic [CURV_W-1:0] CURV_MAX   = {CURV_W{1'b1}};
  localparam logic [CURV_W-1:0] THR_RESET  = CURV_W'(100000);

  typedef struct packed {
    logic full;
    logic empty;
  } pcw_q_status_t;

  // running window sum over 2h+1 coordinates
  function automatic int sum_width(input int h);
    return COORD_W + $clog2(2 * h + 1);
  endfunction

  // frame_last, centre index, centre coords, window sums
  function automatic int job_width(input int h);
    return 1 + IDX_W + 3 * COORD_W + 3 * sum_width(h);
  endfunction

endpackage
`default_nettype wire

>>> hdl/pcw_ifs.sv
// channel interfaces: point input, result output, threshold write
`default_nettype none
interface pcw_point_if import pcw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic                      frame_last;

  modport source (output valid, point_x, point_y, point_z, frame_last, input ready);
  modport sink   (input valid, point_x, point_y, point_z, frame_last, output ready);
endinterface

interface pcw_result_if import pcw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          centre_index;
  logic signed [COORD_W-1:0] centre_x;
  logic signed [COORD_W-1:0] centre_y;
  logic signed [COORD_W-1:0] centre_z;
  logic [CURV_W-1:0]         curvature;
  logic                      above_threshold;
  logic                      below_threshold;
  logic                      frame_end;

  modport source (output valid, centre_index, centre_x, centre_y, centre_z, curvature,
                  above_threshold, below_threshold, frame_end, input ready);
  modport sink   (input valid, centre_index, centre_x, centre_y, centre_z, curvature,
                  above_threshold, below_threshold, frame_end, output ready);
endinterface

interface pcw_cfg_if import pcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CURV_W-1:0] curvature_threshold;

  modport source (output valid, curvature_threshold, input ready);
  modport sink   (input valid, curvature_threshold, output ready);
endinterface
`default_nettype wire

>>> hdl/point_curvature_window.sv
// the point completing a window sends its job through the queue and the back pipe registers
// rate: one point per cycle unless the queue is full; back pipe stages: difference, square, sum
// a point whose window is not yet full gives no result; the window restarts after frame_last
// reset: window, running sums, point count, queue and pipe clear; threshold goes to 100000
// no clearing pass after reset, points are taken as soon as reset is released
`default_nettype none
module point_curvature_window import pcw_pkg::*; #(
  parameter int MAX_POINTS  = 131072,
  parameter int HALF_WINDOW = 5,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  pcw_point_if.sink    pt_i,
  pcw_cfg_if.sink      cfg_i,
  pcw_result_if.source res_o
);

  localparam int JW = job_width(HALF_WINDOW);

  logic              push, pop;
  logic [JW-1:0]     job_in, job_out;
  pcw_q_status_t     q_status;
  logic [CURV_W-1:0] thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.curvature_threshold;
    end
  end

  pcw_front #(
    .MAX_POINTS  (MAX_POINTS),
    .HALF_WINDOW (HALF_WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_i       (pt_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job_in)
  );

  pcw_queue #(
    .WIDTH (JW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_in),
    .pop_i    (pop),
    .data_o   (job_out),
    .status_o (q_status)
  );

  pcw_back #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .job_i      (job_out),
    .pop_o      (pop),
    .thr_i      (thr_q),
    .res_o      (res_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full) else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty) else $error("job popped from empty queue");

  a_thr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready |=> thr_q == $past(cfg_i.curvature_threshold))
    else $error("threshold write lost");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.above_threshold |-> !res_o.below_threshold)
    else $error("both threshold flags set");

endmodule
`default_nettype wire

>>> hdl/pcw_front.sv
// front end: point window, running sums, frame counter, job issue
`default_nettype none
module pcw_front import pcw_pkg::*; #(
  parameter int MAX_POINTS  = 131072,
  parameter int HALF_WINDOW = 5
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  pcw_point_if.sink                            pt_i,
  input  pcw_q_status_t                        q_status_i,
  output logic                                 push_o,
  output logic [job_width(HALF_WINDOW)-1:0]    job_o
);

  localparam int WIN = 2 * HALF_WINDOW + 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int SW  = sum_width(HALF_WINDOW);
  localparam int IW  = (CW > IDX_W) ? CW : IDX_W;

  logic signed [COORD_W-1:0] win_q [WIN][3];
  logic signed [SW-1:0]      sum_q [3];
  logic signed [SW-1:0]      sum_d [3];
  logic signed [COORD_W-1:0] new_pt [3];
  logic [CW-1:0]             cnt_q;
  logic [CW-1:0]             cnt_d;
  logic [IW-1:0]             cidx_w;
  logic [IDX_W-1:0]          cidx;
  logic                      accept;
  logic                      win_full;

  assign pt_i.ready = !q_status_i.full;
  assign accept     = pt_i.valid && pt_i.ready;

  always_comb begin
    new_pt[0] = pt_i.point_x;
    new_pt[1] = pt_i.point_y;
    new_pt[2] = pt_i.point_z;
    cnt_d     = (cnt_q < CW'(MAX_POINTS)) ? cnt_q + 1'b1 : cnt_q;
    win_full  = cnt_d >= CW'(WIN);
    cidx_w    = IW'(cnt_d) - IW'(HALF_WINDOW + 1);
    cidx      = (cidx_w > IW'(INDEX_MAX)) ? IDX_W'(INDEX_MAX) : cidx_w[IDX_W-1:0];
    for (int a = 0; a < 3; a++) begin
      // oldest point leaves, newest enters
      sum_d[a] = sum_q[a] + SW'(new_pt[a]) - SW'(win_q[0][a]);
    end
  end

  assign push_o = accept && win_full;
  // centre after the shift sits one place further in the current window
  assign job_o  = {pt_i.frame_last, cidx,
                   win_q[HALF_WINDOW+1][0], win_q[HALF_WINDOW+1][1], win_q[HALF_WINDOW+1][2],
                   sum_d[0], sum_d[1], sum_d[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
        for (int i = 0; i < WIN; i++) win_q[i][a] <= '0;
      end
    end else if (accept) begin
      if (pt_i.frame_last) begin
        cnt_q <= '0;
        for (int a = 0; a < 3; a++) begin
          sum_q[a] <= '0;
          for (int i = 0; i < WIN; i++) win_q[i][a] <= '0;
        end
      end else begin
        cnt_q <= cnt_d;
        for (int a = 0; a < 3; a++) begin
          sum_q[a] <= sum_d[a];
          for (int i = 0; i < WIN - 1; i++) win_q[i][a] <= win_q[i+1][a];
          win_q[WIN-1][a] <= new_pt[a];
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/pcw_queue.sv
// small job queue between front and back
`default_nettype none
module pcw_queue import pcw_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  wire [WIDTH-1:0]   data_i,
  input  wire               pop_i,
  output logic [WIDTH-1:0]  data_o,
  output pcw_q_status_t     status_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [NW-1:0]    cnt_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign data_o         = mem_q[rd_q];
  assign status_o.full  = cnt_q == NW'(DEPTH);
  assign status_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= next_ptr(wr_q);
      if (pop_i)  rd_q <= next_ptr(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/pcw_back.sv
// back end: difference, square and sum pipe with threshold compare
`default_nettype none
module pcw_back import pcw_pkg::*; #(
  parameter int HALF_WINDOW = 5
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  pcw_q_status_t                      q_status_i,
  input  wire [job_width(HALF_WINDOW)-1:0]   job_i,
  output logic                               pop_o,
  input  wire [CURV_W-1:0]                   thr_i,
  pcw_result_if.source                       res_o
);

  localparam int WIN  = 2 * HALF_WINDOW + 1;
  localparam int SW   = sum_width(HALF_WINDOW);
  localparam int DW   = SW + 1;
  localparam int QW   = 2 * DW;
  localparam int TW   = (QW + 2 > CURV_W + 1) ? QW + 2 : CURV_W + 1;
  localparam int MW   = 1 + IDX_W + 3 * COORD_W;
  localparam logic signed [DW-1:0] WIN_C = DW'(WIN);

  logic                 en;
  logic [MW-1:0]        meta_job;
  logic signed [SW-1:0] sum_in [3];
  logic signed [DW-1:0] diff_d [3];
  logic signed [DW-1:0] diff_q [3];
  logic signed [QW-1:0] dext [3];
  logic [QW-1:0]        sq_d [3];
  logic [QW-1:0]        sq_q [3];
  logic [MW-1:0]        meta1_q, meta2_q;
  logic                 v1_q, v2_q, vo_q;
  logic [TW-1:0]        total;
  logic [CURV_W-1:0]    curv_d;

  logic [IDX_W-1:0]          idx_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [CURV_W-1:0]         curv_q;
  logic                      above_q, below_q, end_q;

  // whole pipe moves unless the output holds an untaken result
  assign en    = !vo_q || res_o.ready;
  assign pop_o = en && !q_status_i.empty;

  assign meta_job  = job_i[3*SW +: MW];
  assign sum_in[0] = job_i[2*SW +: SW];
  assign sum_in[1] = job_i[SW +: SW];
  assign sum_in[2] = job_i[0 +: SW];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // neighbours minus 2h times centre = window sum minus (2h+1) times centre
      diff_d[a] = DW'(sum_in[a]) - DW'($signed(meta_job[(2-a)*COORD_W +: COORD_W])) * WIN_C;
      dext[a]   = QW'(diff_q[a]);
      sq_d[a]   = dext[a] * dext[a];
    end
    total  = TW'(sq_q[0]) + TW'(sq_q[1]) + TW'(sq_q[2]);
    curv_d = (total > TW'(CURV_MAX)) ? CURV_MAX : total[CURV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= !q_status_i.empty;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta1_q <= meta_job;
      meta2_q <= meta1_q;
      for (int a = 0; a < 3; a++) begin
        diff_q[a] <= diff_d[a];
        sq_q[a]   <= sq_d[a];
      end
      end_q   <= meta2_q[MW-1];
      idx_q   <= meta2_q[3*COORD_W +: IDX_W];
      cx_q    <= meta2_q[2*COORD_W +: COORD_W];
      cy_q    <= meta2_q[COORD_W +: COORD_W];
      cz_q    <= meta2_q[0 +: COORD_W];
      curv_q  <= curv_d;
      above_q <= curv_d > thr_i;
      below_q <= curv_d < thr_i;
    end
  end

  assign res_o.valid           = vo_q;
  assign res_o.centre_index    = idx_q;
  assign res_o.centre_x        = cx_q;
  assign res_o.centre_y        = cy_q;
  assign res_o.centre_z        = cz_q;
  assign res_o.curvature       = curv_q;
  assign res_o.above_threshold = above_q;
  assign res_o.below_threshold = below_q;
  assign res_o.frame_end       = end_q;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for the point curvature window
`default_nettype none
module tb_top import pcw_pkg::*; ();

  localparam int          MAX_POINTS    = 131072;
  localparam int          HALF_WINDOW   = 5;
  localparam int          WIN_LEN       = 2 * HALF_WINDOW + 1;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 300;
  localparam longint      CURV_LIMIT    = (longint'(1) << CURV_W) - 1;
  localparam logic [CURV_W-1:0] THR_HIGH = CURV_W'(64'd21000000000000);

  typedef enum int unsigned {SCAN_SMOOTH, SCAN_NOISE, SCAN_EXTREME} scan_style_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [CURV_W-1:0]  curv;
    logic               above;
    logic               below;
    logic               fend;
  } curv_result_t;

  logic clk_i;
  logic rst_ni;

  pcw_point_if  pt_if ();
  pcw_cfg_if    cfg_if ();
  pcw_result_if res_if ();

  point_curvature_window dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  point_t            pending_points[$];
  curv_result_t      expected_curvatures[$];
  point_t            scan_window[WIN_LEN];
  int unsigned       frame_points;
  logic [CURV_W-1:0] threshold_shadow;
  int unsigned       tx_idle_pct;
  int unsigned       rx_stall_pct;
  logic              hold_go;
  logic              rx_hold;
  int unsigned       fail_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint axis_value(input point_t p, input int unsigned a);
    case (a)
      0:       return longint'($signed(p.x));
      1:       return longint'($signed(p.y));
      default: return longint'($signed(p.z));
    endcase
  endfunction

  task automatic clear_scan_window();
    for (int i = 0; i < WIN_LEN; i++) scan_window[i] = '0;
    frame_points = 0;
  endtask

  // shift in one accepted point and queue the curvature it completes, if any
  task automatic advance_window(input point_t p);
    longint       diff;
    longint       curv;
    int unsigned  cidx;
    curv_result_t r;
    for (int i = 0; i < WIN_LEN - 1; i++) scan_window[i] = scan_window[i + 1];
    scan_window[WIN_LEN - 1] = p;
    if (frame_points < MAX_POINTS) frame_points++;
    if (frame_points >= WIN_LEN) begin
      curv = 0;
      for (int a = 0; a < 3; a++) begin
        diff = 0;
        for (int i = 0; i < WIN_LEN; i++) begin
          if (i != HALF_WINDOW) diff += axis_value(scan_window[i], a);
        end
        diff -= 2 * HALF_WINDOW * axis_value(scan_window[HALF_WINDOW], a);
        curv += diff * diff;
      end
      if (curv > CURV_LIMIT) curv = CURV_LIMIT;
      cidx = frame_points - 1 - HALF_WINDOW;
      if (cidx > INDEX_MAX) cidx = INDEX_MAX;
      r.idx   = cidx[IDX_W-1:0];
      r.x     = scan_window[HALF_WINDOW].x;
      r.y     = scan_window[HALF_WINDOW].y;
      r.z     = scan_window[HALF_WINDOW].z;
      r.curv  = curv[CURV_W-1:0];
      r.above = r.curv > threshold_shadow;
      r.below = r.curv < threshold_shadow;
      r.fend  = p.last;
      expected_curvatures.insert(expected_curvatures.size(), r);
    end
    if (p.last) clear_scan_window();
  endtask

  task automatic compare_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      fail_count++;
    end
  endtask

  // point driver
  always @(posedge clk_i) begin : point_driver
    point_t nxt;
    if (!rst_ni) begin
      pt_if.valid <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        advance_window('{pt_if.point_x, pt_if.point_y, pt_if.point_z, pt_if.frame_last});
      end
      if (!pt_if.valid || pt_if.ready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_points.pop_front();
          pt_if.valid      <= 1'b1;
          pt_if.point_x    <= nxt.x;
          pt_if.point_y    <= nxt.y;
          pt_if.point_z    <= nxt.z;
          pt_if.frame_last <= nxt.last;
        end else begin
          pt_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk_i) begin : result_monitor
    curv_result_t got;
    curv_result_t want;
    if (res_if.valid && res_if.ready) begin
      got = '{res_if.centre_index, res_if.centre_x, res_if.centre_y, res_if.centre_z,
              res_if.curvature, res_if.above_threshold, res_if.below_threshold,
              res_if.frame_end};
      if (expected_curvatures.size() == 0) begin
        $error("unexpected result transfer: centre_index %0d", got.idx);
        fail_count++;
      end else begin
        want = expected_curvatures.pop_front();
        compare_field("centre_index",    want.idx,   got.idx);
        compare_field("centre_x",        want.x,     got.x);
        compare_field("centre_y",        want.y,     got.y);
        compare_field("centre_z",        want.z,     got.z);
        compare_field("curvature",       want.curv,  got.curv);
        compare_field("above_threshold", want.above, got.above);
        compare_field("below_threshold", want.below, got.below);
        compare_field("frame_end",       want.fend,  got.fend);
      end
    end
    res_if.ready <= rst_ni && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial begin : rx_hold_counter
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic queue_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic last);
    point_t p;
    p = '{x, y, z, last};
    pending_points.insert(pending_points.size(), p);
  endtask

  function automatic logic [COORD_W-1:0] extreme_coord();
    case ($urandom_range(4))
      0:       return {1'b1, {(COORD_W-1){1'b0}}};
      1:       return {1'b0, {(COORD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return COORD_W'(1);
    endcase
  endfunction

  task automatic queue_frame(input int unsigned n_points, input scan_style_e style,
                             input logic close_frame);
    logic [COORD_W-1:0] base[3];
    for (int a = 0; a < 3; a++) base[a] = COORD_W'($urandom_range(262143));
    for (int unsigned k = 0; k < n_points; k++) begin
      for (int a = 0; a < 3; a++) begin
        case (style)
          SCAN_NOISE:   base[a] = COORD_W'($urandom_range(262143));
          SCAN_EXTREME: base[a] = extreme_coord();
          default: begin
            // small steps along the scan with an occasional jump to a new random coordinate
            base[a] = base[a] + COORD_W'($urandom_range(64)) - COORD_W'(32);
            if ($urandom_range(24) == 0) base[a] = COORD_W'($urandom_range(262143));
          end
        endcase
      end
      queue_point(base[0], base[1], base[2], close_frame && (k == n_points - 1));
    end
  endtask

  task automatic run_random_frames(input int unsigned n_items);
    int unsigned queued;
    int unsigned len;
    int unsigned pick;
    scan_style_e style;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(9);
      if (pick == 0)      len = $urandom_range(1, WIN_LEN - 1);
      else if (pick == 1) len = WIN_LEN;
      else                len = $urandom_range(WIN_LEN + 1, 60);
      pick = $urandom_range(9);
      if (pick < 6)      style = SCAN_SMOOTH;
      else if (pick < 9) style = SCAN_NOISE;
      else               style = SCAN_EXTREME;
      @(negedge clk_i);
      queue_frame(len, style, 1'b1);
      queued += len;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_points.size() != 0 || pt_if.valid || expected_curvatures.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [CURV_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid               <= 1'b1;
    cfg_if.curvature_threshold <= value;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid     <= 1'b0;
    threshold_shadow = value;
  endtask

  initial begin : stimulus
    rst_ni                     = 1'b0;
    pt_if.valid                = 1'b0;
    pt_if.point_x              = '0;
    pt_if.point_y              = '0;
    pt_if.point_z              = '0;
    pt_if.frame_last           = 1'b0;
    cfg_if.valid               = 1'b0;
    cfg_if.curvature_threshold = '0;
    res_if.ready               = 1'b0;
    hold_go                    = 1'b0;
    tx_idle_pct                = 0;
    rx_stall_pct               = 0;
    fail_count                 = 0;
    threshold_shadow           = THR_RESET;
    clear_scan_window();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // largest curvature: centre at the positive extreme, neighbours at the negative one
    @(negedge clk_i);
    for (int k = 0; k < WIN_LEN; k++) begin
      if (k == HALF_WINDOW) queue_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, k == WIN_LEN - 1);
      else                  queue_point(18'h20000, 18'h20000, 18'h20000, k == WIN_LEN - 1);
    end
    // short frame never fills the window
    queue_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 1'b0);
    queue_point(18'h3FFFF, 18'h00000, 18'h00001, 1'b1);
    wait_idle();

    // curvature of exactly 100 against a threshold of 100 sets neither flag
    write_threshold(CURV_W'(100));
    @(negedge clk_i);
    for (int k = 0; k < WIN_LEN + 1; k++) begin
      queue_point((k == HALF_WINDOW) ? 18'h00001 : 18'h00000, '0, '0, k == WIN_LEN);
    end
    run_random_frames(100);
    // frame split around a full drain, window must survive the pause
    @(negedge clk_i);
    queue_frame(20, SCAN_SMOOTH, 1'b0);
    wait_idle();
    @(negedge clk_i);
    queue_frame(17, SCAN_NOISE, 1'b1);
    run_random_frames(100);
    wait_idle();

    write_threshold('0);
    tx_idle_pct = 48;
    run_random_frames(200);
    wait_idle();

    write_threshold(THR_HIGH);
    tx_idle_pct  = 0;
    rx_stall_pct = 48;
    hold_go      = 1'b1;
    run_random_frames(200);
    wait_idle();

    write_threshold(CURV_W'({$urandom_range(255), $urandom}));
    tx_idle_pct  = 10;
    rx_stall_pct = 10;
    run_random_frames(200);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (expected_curvatures.size() != 0) begin
      $error("%0d expected results never arrived", expected_curvatures.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $error("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
